// ----- rtl/core/alt_pkg.sv -----
// alt_pkg: request kinds, status codes and fixed field widths of the array list engine.
// No dependencies; used by the top level and its checker.
`default_nettype none

package alt_pkg;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 9;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam req_t REQ_PUSH   = 2'd0;
  localparam req_t REQ_POP    = 2'd1;
  localparam req_t REQ_READ   = 2'd2;
  localparam req_t REQ_DELETE = 2'd3;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_EMPTY    = 3'd2;
  localparam status_t ST_RANGE    = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

endpackage

`default_nettype wire

// ----- rtl/core/array_list_table_engine_top.sv -----
// Array list engine: a compact list of signed 32-bit values held in one synchronous RAM.
// Depends on alt_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: in_req_type, in_value,
//   in_index. Result channel (out_valid / out_stall) carries one result per request:
//   out_read_value, out_status, out_count. A request is taken when valid is high and
//   stall is low at a rising clock edge.
//   One request is in work at a time. Steps from acceptance to result:
//     push, pop, failed read, delete on an empty list : result registered on acceptance
//     read in range                                   : one RAM read, then the result
//     delete on a non-empty list, found or not        : the RAM read port
//                                                       scans one entry per cycle up to
//                                                       the match, then moves one later
//                                                       entry per cycle.
//   Sustained rate, while out_stall is low, is one push, pop, failed read or delete on
//   an empty list per cycle. The result sits in an output register; a new request is
//   taken in the cycle the receiver takes the previous result. While out_stall is high
//   the result holds and in_stall rises. Reset (synchronous, rst_n low) empties the
//   list and drops any pending result; RAM contents are left as they are.
`default_nettype none

module array_list_table_engine_top #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [alt_pkg::REQ_W-1:0]            in_req_type,
  input  wire logic signed [alt_pkg::VALUE_W-1:0]   in_value,
  input  wire logic [alt_pkg::INDEX_W-1:0]          in_index,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [alt_pkg::VALUE_W-1:0]        out_read_value,
  output logic [alt_pkg::STATUS_W-1:0]              out_status,
  output logic [alt_pkg::COUNT_W-1:0]               out_count
);

  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > alt_pkg::INDEX_W) ? CNT_W : alt_pkg::INDEX_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  logic [alt_pkg::VALUE_W-1:0] mem [CAPACITY];

  logic [1:0]                  state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [AW-1:0]               ptr_r, ptr_nxt;
  logic [alt_pkg::VALUE_W-1:0] key_r, key_nxt;
  logic [alt_pkg::VALUE_W-1:0] rdata_r;

  logic                        out_valid_r;
  logic [alt_pkg::VALUE_W-1:0] out_value_r;
  alt_pkg::status_t            out_status_r;
  logic [alt_pkg::COUNT_W-1:0] out_count_r;

  logic                        accept;
  logic                        out_free;
  logic                        re, we;
  logic [AW-1:0]               raddr, waddr;
  logic [alt_pkg::VALUE_W-1:0] wdata;
  logic                        res_valid;
  logic [alt_pkg::VALUE_W-1:0] res_value;
  alt_pkg::status_t            res_status;
  logic [CNT_W-1:0]            ptr1, ptr2;
  logic                        full, empty, in_range;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !rst_n || (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);
  assign in_range = (CMP_W'(in_index) < CMP_W'(count_r));
  assign ptr1     = CNT_W'(ptr_r) + CNT_W'(1);
  assign ptr2     = CNT_W'(ptr_r) + CNT_W'(2);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    key_nxt    = key_r;
    re         = 1'b0;
    raddr      = '0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    res_valid  = 1'b0;
    res_value  = '0;
    res_status = alt_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req_type)
            alt_pkg::REQ_PUSH: begin
              res_valid = 1'b1;
              if (full) begin
                res_status = alt_pkg::ST_FULL;
              end else begin
                we        = 1'b1;
                waddr     = AW'(count_r);
                wdata     = in_value;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            alt_pkg::REQ_POP: begin
              res_valid = 1'b1;
              if (empty) begin
                res_status = alt_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            alt_pkg::REQ_READ: begin
              if (in_range) begin
                re        = 1'b1;
                raddr     = AW'(in_index);
                state_nxt = S_READ;
              end else begin
                res_valid  = 1'b1;
                res_status = alt_pkg::ST_RANGE;
              end
            end
            default: begin
              if (empty) begin
                res_valid  = 1'b1;
                res_status = alt_pkg::ST_NOTFOUND;
              end else begin
                re        = 1'b1;
                raddr     = '0;
                ptr_nxt   = '0;
                key_nxt   = in_value;
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end
      S_READ: begin
        res_valid = 1'b1;
        res_value = rdata_r;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (rdata_r == key_r) begin
          if (ptr1 < count_r) begin
            re        = 1'b1;
            raddr     = AW'(ptr1);
            state_nxt = S_SHIFT;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            res_valid = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (ptr1 < count_r) begin
          re      = 1'b1;
          raddr   = AW'(ptr1);
          ptr_nxt = AW'(ptr1);
        end else begin
          res_valid  = 1'b1;
          res_status = alt_pkg::ST_NOTFOUND;
          state_nxt  = S_IDLE;
        end
      end
      S_SHIFT: begin
        we    = 1'b1;
        waddr = ptr_r;
        wdata = rdata_r;
        if (ptr2 < count_r) begin
          re      = 1'b1;
          raddr   = AW'(ptr2);
          ptr_nxt = AW'(ptr1);
        end else begin
          count_nxt = count_r - CNT_W'(1);
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    key_r <= key_nxt;
    if (res_valid) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
      out_count_r  <= alt_pkg::COUNT_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;

endmodule

`default_nettype wire

// ----- rtl/core/alt_checker.sv -----
// alt_checker: port-level checks of the array list engine, bound to the top level.
// Depends on alt_pkg and array_list_table_engine_top.
`default_nettype none

module alt_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic [alt_pkg::VALUE_W-1:0]        out_read_value,
  input wire logic [alt_pkg::STATUS_W-1:0]       out_status,
  input wire logic [alt_pkg::COUNT_W-1:0]        out_count
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_count)
      && $stable(out_read_value))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= alt_pkg::ST_NOTFOUND)
    else $error("undefined status code");

  a_fail_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != alt_pkg::ST_OK |-> out_read_value == '0)
    else $error("failed request returned nonzero value");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while result stalled");

endmodule

bind array_list_table_engine_top alt_checker u_alt_checker (.*);

`default_nettype wire
